[design/rte_pkg.sv]
// shared types and constants for the rank transform engine
package rte_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned RANK_W  = 6;

  // xor with this turns signed order into unsigned order
  localparam logic [VALUE_W-1:0] SIGN_FLIP = {1'b1, {(VALUE_W-1){1'b0}}};

  // a key travelling down the chain with its running count of smaller keys
  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] key;
    logic [RANK_W-1:0]  cnt;
  } tok_t;

  // what a cell shows to the top level and to its left neighbor
  typedef struct packed {
    logic              busy;
    logic              occ;
    logic [RANK_W-1:0] rank;
  } cell_stat_t;

  // control states, one-hot
  typedef enum logic [2:0] {
    ST_LOAD   = 3'b001,
    ST_DRAIN  = 3'b010,
    ST_UNLOAD = 3'b100
  } state_e;

endpackage

[design/rte_if.sv]
// request and result channels of the rank transform engine
interface rte_in_if;
  logic                        valid;
  logic                        ready;
  logic signed [rte_pkg::VALUE_W-1:0] value_in;
  logic                        last_item;

  modport source (output valid, output value_in, output last_item, input ready);
  modport sink   (input valid, input value_in, input last_item, output ready);
endinterface

interface rte_out_if;
  logic                        valid;
  logic                        ready;
  logic [rte_pkg::RANK_W-1:0]  rank_out;
  logic                        last_rank;
  logic                        overflow;

  modport source (output valid, output rank_out, output last_rank, output overflow,
                  input ready);
  modport sink   (input valid, input rank_out, input last_rank, input overflow,
                  output ready);
endinterface

[design/rank_transform_engine_top.sv]
// rank transform engine: chain of cells that ranks a set of signed values
// a key passes through the token register of each occupied cell until it finds a free one
// loading takes one value per cycle; after the last value the chain drains until no
// cell holds a token in flight, then shifts out one rank per cycle to out_o while
// out_o does not stall, and takes requests again once cell 0 is empty
// reset: asynchronous active low, clears the chain, the counters and the output
module rank_transform_engine_top #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rte_in_if.sink     in_i,
  rte_out_if.source  out_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  rte_pkg::state_e               state_q, state_d;
  logic [CNT_W-1:0]              count_q;
  logic                          ovf_q;
  logic                          full;
  logic                          accept;
  logic                          shift;
  logic                          any_busy;
  logic                          out_valid_q;
  logic [rte_pkg::RANK_W-1:0]    out_rank_q;
  logic                          out_last_q;
  logic                          out_ovf_q;
  rte_pkg::tok_t                 tok_in;
  rte_pkg::tok_t                 tok  [MAX_ITEMS+1];
  rte_pkg::cell_stat_t           stat [MAX_ITEMS+1];
  logic [MAX_ITEMS-1:0]          busy_vec;

  assign full        = (count_q == CNT_W'(MAX_ITEMS));
  assign in_i.ready  = (state_q == rte_pkg::ST_LOAD);
  assign accept      = in_i.valid && in_i.ready;

  // new key enters cell 0 unless the set is full
  always_comb begin
    tok_in.valid = accept && !full;
    tok_in.key   = in_i.value_in ^ rte_pkg::SIGN_FLIP;
    tok_in.cnt   = '0;
  end
  assign tok[0] = tok_in;

  // beyond the last cell the chain reads empty
  assign stat[MAX_ITEMS] = '0;

  assign shift = (state_q == rte_pkg::ST_UNLOAD) && stat[0].occ &&
                 (!out_valid_q || out_o.ready);

  // chain of cells
  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    rte_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tok_i   (tok[g]),
      .tok_o   (tok[g+1]),
      .shift_i (shift),
      .nbr_i   (stat[g+1]),
      .stat_o  (stat[g])
    );
    assign busy_vec[g] = stat[g].busy;
  end

  assign any_busy = |busy_vec;

  // load, drain, unload sequence
  always_comb begin
    state_d = state_q;
    case (state_q)
      rte_pkg::ST_LOAD: begin
        if (accept && in_i.last_item) state_d = rte_pkg::ST_DRAIN;
      end
      rte_pkg::ST_DRAIN: begin
        if (!any_busy) state_d = rte_pkg::ST_UNLOAD;
      end
      rte_pkg::ST_UNLOAD: begin
        if (!stat[0].occ) state_d = rte_pkg::ST_LOAD;
      end
      default: state_d = rte_pkg::ST_LOAD;
    endcase
  end

  // control state, item count, overflow flag and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rte_pkg::ST_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + CNT_W'(1);
        end
      end else if (state_q == rte_pkg::ST_UNLOAD && !stat[0].occ) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end
      if (shift) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (shift) begin
      out_rank_q <= stat[0].rank;
      out_last_q <= !stat[1].occ;
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.rank_out  = out_rank_q;
  assign out_o.last_rank = out_last_q;
  assign out_o.overflow  = out_ovf_q;

endmodule

[design/rte_cell.sv]
// one cell of the ranking chain: holds one key and its running rank
module rte_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rte_pkg::tok_t       tok_i,
  output rte_pkg::tok_t       tok_o,
  input  logic                shift_i,
  input  rte_pkg::cell_stat_t nbr_i,
  output rte_pkg::cell_stat_t stat_o
);

  logic                         tok_vld_q;
  logic [rte_pkg::VALUE_W-1:0]  tok_key_q;
  logic [rte_pkg::RANK_W-1:0]   tok_cnt_q;
  logic                         occ_q;
  logic [rte_pkg::VALUE_W-1:0]  key_q;
  logic [rte_pkg::RANK_W-1:0]   rank_q;
  logic                         less;
  logic                         greater;

  // compare the passing key against the held one
  assign less    = occ_q && (key_q < tok_key_q);
  assign greater = occ_q && (key_q > tok_key_q);

  // token moves on only if this cell is already taken
  always_comb begin
    tok_o.valid = tok_vld_q && occ_q;
    tok_o.key   = tok_key_q;
    tok_o.cnt   = tok_cnt_q + {{(rte_pkg::RANK_W-1){1'b0}}, less};
  end

  assign stat_o.busy = tok_vld_q;
  assign stat_o.occ  = occ_q;
  assign stat_o.rank = rank_q;

  // token valid and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
      occ_q     <= 1'b0;
    end else begin
      tok_vld_q <= tok_i.valid;
      if (shift_i) begin
        occ_q <= nbr_i.occ;
      end else if (tok_vld_q && !occ_q) begin
        occ_q <= 1'b1;
      end
    end
  end

  // token payload, key and rank
  always_ff @(posedge clk_i) begin
    tok_key_q <= tok_i.key;
    tok_cnt_q <= tok_i.cnt;
    if (shift_i) begin
      rank_q <= nbr_i.rank;
    end else if (tok_vld_q) begin
      if (!occ_q) begin
        key_q  <= tok_key_q;
        rank_q <= tok_cnt_q;
      end else if (greater) begin
        rank_q <= rank_q + rte_pkg::RANK_W'(1);
      end
    end
  end

endmodule

[verif/tb_rank_transform_engine_top.sv]
// self-checking testbench for the rank transform engine top level
module tb_rank_transform_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VALUE_W    = rte_pkg::VALUE_W;
  localparam int unsigned RANK_W     = rte_pkg::RANK_W;
  localparam int unsigned CAP        = 64;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned HOLD_LEN   = 300;
  localparam int unsigned PHASE_REQS = 96;
  localparam logic signed [VALUE_W-1:0] INT_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] INT_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  // one request: a set element and its end-of-set flag
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } rank_req_t;

  // one predicted result
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              last;
    logic              ovf;
  } rank_res_t;

  // value classes used when building random sets
  typedef enum int {
    VAL_FULL,
    VAL_NARROW,
    VAL_EDGE
  } val_kind_e;

  logic clk_i;
  logic rst_ni;

  rte_in_if  in_if ();
  rte_out_if out_if ();

  rank_transform_engine_top #(
    .MAX_ITEMS (CAP)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  rank_req_t req_q[$];
  rank_res_t rank_exp_q[$];

  // predictor state for the set being loaded
  logic signed [VALUE_W-1:0] set_values [CAP];
  logic [RANK_W-1:0]         set_ranks [CAP];
  int unsigned               set_fill;
  bit                        set_dropped;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_arm;
  bit          hold_done;
  int unsigned hold_cnt;
  int unsigned idle_cycles;
  int unsigned err_cnt;
  int unsigned reqs_sent;
  int unsigned sets_done;
  int unsigned ovf_sets;
  int unsigned ranks_checked;
  int unsigned max_set;

  // clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // rank prediction for one accepted request
  function automatic void rank_update(input logic signed [VALUE_W-1:0] v,
                                      input logic lst);
    int unsigned smaller;
    int unsigned j;
    rank_res_t   res;
    smaller = 0;
    if (set_fill < CAP) begin
      for (j = 0; j < set_fill; j++) begin
        if (set_values[j] < v) begin
          smaller++;
        end else if (set_values[j] > v) begin
          set_ranks[j] = set_ranks[j] + 1'b1;
        end
      end
      set_values[set_fill] = v;
      set_ranks[set_fill]  = smaller[RANK_W-1:0];
      set_fill++;
    end else begin
      set_dropped = 1'b1;
    end
    if (lst) begin
      for (j = 0; j < set_fill; j++) begin
        res.rank = set_ranks[j];
        res.last = (j + 1 == set_fill);
        res.ovf  = set_dropped;
        rank_exp_q.push_back(res);
      end
      sets_done++;
      if (set_dropped) ovf_sets++;
      if (set_fill > max_set) max_set = set_fill;
      set_fill    = 0;
      set_dropped = 1'b0;
    end
  endfunction

  // random element value, biased toward duplicates and edge values
  function automatic logic signed [VALUE_W-1:0] pick_value(input val_kind_e kind);
    logic signed [VALUE_W-1:0] v;
    case (kind)
      VAL_NARROW: begin
        v = $signed($urandom_range(0, 6)) - 3;
      end
      VAL_EDGE: begin
        case ($urandom_range(0, 3))
          0: v = INT_MIN;
          1: v = INT_MAX;
          2: v = -1;
          default: v = 0;
        endcase
      end
      default: begin
        v = $urandom;
      end
    endcase
    return v;
  endfunction

  // queue one set of n random elements, last flag on the final one
  function automatic void add_random_set(input int unsigned n);
    rank_req_t   r;
    val_kind_e   kind;
    int unsigned sel;
    int unsigned i;
    for (i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 5) kind = VAL_FULL;
      else if (sel < 8) kind = VAL_NARROW;
      else kind = VAL_EDGE;
      r.value = pick_value(kind);
      r.last  = (i + 1 == n);
      req_q.push_back(r);
    end
  endfunction

  // queue one set given element by element
  function automatic void add_fixed_set(input logic signed [VALUE_W-1:0] vals[$]);
    rank_req_t   r;
    int unsigned i;
    for (i = 0; i < vals.size(); i++) begin
      r.value = vals[i];
      r.last  = (i + 1 == vals.size());
      req_q.push_back(r);
    end
  endfunction

  // mostly short sets, now and then one around capacity
  function automatic void add_random_phase(input int unsigned budget);
    int unsigned added;
    int unsigned n;
    added = 0;
    while (added < budget) begin
      if ($urandom_range(0, 14) == 0) n = $urandom_range(CAP - 4, CAP + 4);
      else n = $urandom_range(1, 10);
      add_random_set(n);
      added += n;
    end
  endfunction

  // request driver
  always @(posedge clk_i) begin
    rank_req_t nxt;
    logic      offer;
    logic      take;
    if (rst_ni) begin
      take = in_if.valid && in_if.ready;
      if (take) begin
        rank_update(in_if.value_in, in_if.last_item);
        reqs_sent++;
      end
      if (in_if.valid && !take) begin
        offer = 1'b1;
      end else if (req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = req_q.pop_front();
        in_if.value_in  <= nxt.value;
        in_if.last_item <= nxt.last;
        offer = 1'b1;
      end else begin
        offer = 1'b0;
      end
      in_if.valid <= offer;
    end
  end

  // long receiver hold-off, started once on the first result it sees after it is armed
  always @(posedge clk_i) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_arm && !hold_done && out_if.valid) begin
      hold_cnt  <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  // receiver ready
  always @(posedge clk_i) begin
    if (!rst_ni || hold_cnt != 0) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    rank_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (rank_exp_q.size() == 0) begin
        $error("unexpected result: rank_out %0d last_rank %0b overflow %0b",
               out_if.rank_out, out_if.last_rank, out_if.overflow);
        err_cnt++;
      end else begin
        want = rank_exp_q.pop_front();
        ranks_checked++;
        if (out_if.rank_out !== want.rank) begin
          $error("rank_out: expected %0d, actual %0d", want.rank, out_if.rank_out);
          err_cnt++;
        end
        if (out_if.last_rank !== want.last) begin
          $error("last_rank: expected %0b, actual %0b", want.last, out_if.last_rank);
          err_cnt++;
        end
        if (out_if.overflow !== want.ovf) begin
          $error("overflow: expected %0b, actual %0b", want.ovf, out_if.overflow);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d results pending",
               IDLE_LIMIT, rank_exp_q.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.value_in  = '0;
    in_if.last_item = 1'b0;
    out_if.ready    = 1'b0;
    send_idle_pct   = 34;
    recv_idle_pct   = 81;
    hold_arm        = 1'b0;
    hold_done       = 1'b0;
    hold_cnt        = 0;
    idle_cycles     = 0;
    err_cnt         = 0;
    reqs_sent       = 0;
    sets_done       = 0;
    ovf_sets        = 0;
    ranks_checked   = 0;
    max_set         = 0;
    set_fill        = 0;
    set_dropped     = 1'b0;

    // directed sets: single extremes, mixed extremes, ties, monotonic runs
    add_fixed_set('{INT_MAX});
    add_fixed_set('{INT_MIN});
    add_fixed_set('{0, -1, INT_MIN, INT_MAX, 1});
    add_fixed_set('{5, 5, 7});
    add_fixed_set('{-1, -1, -1, -1});
    add_fixed_set('{4, 3, 2, 1, 0});
    add_fixed_set('{-3, -2, -1, 0});

    // phase one: a full set exactly at capacity, then random sets
    add_random_set(CAP);
    add_random_phase(PHASE_REQS - CAP);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() != 0 || rank_exp_q.size() != 0) @(posedge clk_i);

    // phase two: roles swapped, capacity exceeded with the last element dropped
    @(negedge clk_i);
    send_idle_pct = 81;
    recv_idle_pct = 34;
    add_random_set(CAP + 1);
    add_random_phase(PHASE_REQS - CAP);
    while (req_q.size() != 0 || rank_exp_q.size() != 0) @(posedge clk_i);

    // phase three: no idling, receiver stalls hard once while requests keep coming
    @(negedge clk_i);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_arm      = 1'b1;
    add_random_phase(PHASE_REQS);
    while (req_q.size() != 0 || rank_exp_q.size() != 0 || in_if.valid) @(posedge clk_i);

    // let the chain settle and catch any stray results
    repeat (2 * CAP + 8) @(posedge clk_i);

    $display("covered %0d requests in %0d sets (largest %0d, %0d over capacity)",
             reqs_sent, sets_done, max_set, ovf_sets);
    $display("checked %0d ranks, %0d mismatches", ranks_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
design/rte_pkg.sv
design/rte_if.sv
design/rte_cell.sv
design/rank_transform_engine_top.sv
verif/tb_rank_transform_engine_top.sv
